// File: design/pcgb_pkg.sv
// Shared types and constants for the pulse counter with gap bridging.
package pcgb_pkg;

  localparam int OUT_W = 32;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 8;
  localparam int GAP_W = 8;
  localparam int MRG_W = 4;
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  localparam logic [OUT_W-1:0] OUT_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] REG_GAP_MIN = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_MERGES = 8'd1;

  localparam logic [GAP_W-1:0] GAP_MIN_RST = 8'd8;
  localparam logic [MRG_W-1:0] MAX_MERGES_RST = 4'd4;

  localparam logic KIND_PULSE = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HIGH = 2'd1,
    PH_LOW  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [GAP_W-1:0] gap_min;
    logic [MRG_W-1:0] max_merges;
  } cfg_t;

  typedef struct packed {
    logic             record_kind;
    logic [OUT_W-1:0] pulse_length;
    logic [OUT_W-1:0] gap_length;
    logic [OUT_W-1:0] pulse_total;
    logic             last;
  } res_t;

endpackage

// File: design/pcgb_if.sv
// Channel interfaces for samples, result records and register writes.
interface pcgb_in_if;
  logic valid;
  logic ready;
  logic sample;
  logic final_req;
  modport source (output valid, sample, final_req, input ready);
  modport sink (input valid, sample, final_req, output ready);
endinterface

interface pcgb_out_if;
  logic        valid;
  logic        ready;
  logic        record_kind;
  logic [31:0] pulse_length;
  logic [31:0] gap_length;
  logic [31:0] pulse_total;
  logic        last;
  modport source (output valid, record_kind, pulse_length, gap_length, pulse_total, last,
                  input ready);
  modport sink (input valid, record_kind, pulse_length, gap_length, pulse_total, last,
                output ready);
endinterface

interface pcgb_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: design/pulse_counter_gap_bridging_top.sv
// Top level of the pulse counter with gap bridging.
// Each sample is first registered at the input; when the result queue has room, the core
// writes its records into the queue, from which they are offered on the result channel.
// Throughput: one sample per cycle; a final sample that closes a pulse gives
// two records, which leave through the result queue one after the other. Samples stall
// only while the result queue holds more than two records.
// Reset (synchronous, active low) clears the capture state and the queue and
// loads gap_min with 8 and max_merges with 4.
module pulse_counter_gap_bridging_top #(
  parameter int COUNT_WIDTH = 32
) (
  input logic        clk,
  input logic        rst_n,
  pcgb_in_if.sink    in_ch,
  pcgb_out_if.source out_ch,
  pcgb_cfg_if.sink   cfg_ch
);
  import pcgb_pkg::*;

  cfg_t       cfg_r;
  logic       in_valid_r, in_sample_r, in_final_r;
  logic       go, room2, q_valid;
  logic [1:0] n_push;
  res_t       res0, res1, q_dout;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gap_min <= GAP_MIN_RST;
      cfg_r.max_merges <= MAX_MERGES_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_GAP_MIN:    cfg_r.gap_min <= cfg_ch.data[GAP_W-1:0];
        REG_MAX_MERGES: cfg_r.max_merges <= cfg_ch.data[MRG_W-1:0];
        default: ;
      endcase
    end
  end

  assign go = in_valid_r && room2;
  assign in_ch.ready = !in_valid_r || go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready) begin
      in_sample_r <= in_ch.sample;
      in_final_r <= in_ch.final_req;
    end
  end

  pcgb_core #(.CW(COUNT_WIDTH)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go),
    .sample    (in_sample_r),
    .final_req (in_final_r),
    .cfg       (cfg_r),
    .res0      (res0),
    .res1      (res1),
    .n_push    (n_push)
  );

  pcgb_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .n_push (n_push),
    .d0     (res0),
    .d1     (res1),
    .pop    (out_ch.ready),
    .room2  (room2),
    .valid  (q_valid),
    .dout   (q_dout)
  );

  assign out_ch.valid = q_valid;
  assign out_ch.record_kind = q_dout.record_kind;
  assign out_ch.pulse_length = q_dout.pulse_length;
  assign out_ch.gap_length = q_dout.gap_length;
  assign out_ch.pulse_total = q_dout.pulse_total;
  assign out_ch.last = q_dout.last;

endmodule

// File: design/pcgb_core.sv
// Pulse tracking state and record generation for one sample per cycle.
module pcgb_core #(
  parameter int CW = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           go,
  input  logic           sample,
  input  logic           final_req,
  input  pcgb_pkg::cfg_t cfg,
  output pcgb_pkg::res_t res0,
  output pcgb_pkg::res_t res1,
  output logic [1:0]     n_push
);
  import pcgb_pkg::*;

  localparam logic [CW-1:0] CMAX = '1;
  localparam int EW = (CW > OUT_W) ? CW : OUT_W;

  function automatic logic [CW-1:0] sat_add(logic [CW-1:0] a, logic [CW-1:0] b);
    logic [CW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CW] ? CMAX : s[CW-1:0];
  endfunction

  function automatic logic [OUT_W-1:0] out32(logic [CW-1:0] v);
    logic [EW-1:0] e;
    e = EW'(v);
    return (e > EW'(OUT_MAX)) ? OUT_MAX : e[OUT_W-1:0];
  endfunction

  phase_t           phase_r, phase_nxt, ph_a;
  logic [CW-1:0]    cur_len_r, cur_len_nxt, len_a;
  logic [CW-1:0]    cur_gap_r, cur_gap_nxt, gap_a;
  logic [MRG_W-1:0] merges_r, merges_nxt, mrg_a;
  logic [CW-1:0]    seen_r, seen_nxt, seen_a;
  logic [CW-1:0]    sum_r, sum_nxt, sum_a;
  logic [CW-1:0]    tail, sum_f, gap_min_w, one_w;
  logic             close;
  res_t             rec_close, rec_sum;

  assign gap_min_w = CW'(cfg.gap_min);
  assign one_w = CW'(1);
  assign close = (phase_r == PH_LOW) && sample &&
                 ((cur_gap_r >= gap_min_w) || (merges_r >= cfg.max_merges));

  always_comb begin
    ph_a = phase_r;
    case (phase_r)
      PH_IDLE: if (sample) ph_a = PH_HIGH;
      PH_HIGH: if (!sample) ph_a = PH_LOW;
      PH_LOW:  if (sample) ph_a = PH_HIGH;
      default: ph_a = PH_IDLE;
    endcase
    phase_nxt = final_req ? PH_IDLE : ph_a;
  end

  always_comb begin
    len_a = cur_len_r;
    gap_a = cur_gap_r;
    mrg_a = merges_r;
    seen_a = seen_r;
    sum_a = sum_r;
    case (phase_r)
      PH_IDLE: begin
        if (sample) begin
          len_a = one_w;
          gap_a = '0;
          mrg_a = '0;
        end
      end
      PH_HIGH: begin
        if (sample) begin
          len_a = sat_add(cur_len_r, one_w);
        end else begin
          gap_a = one_w;
        end
      end
      PH_LOW: begin
        if (!sample) begin
          gap_a = sat_add(cur_gap_r, one_w);
        end else if (close) begin
          seen_a = sat_add(seen_r, one_w);
          sum_a = sat_add(sum_r, cur_len_r);
          len_a = one_w;
          gap_a = '0;
          mrg_a = '0;
        end else begin
          len_a = sat_add(sat_add(cur_len_r, cur_gap_r), one_w);
          gap_a = '0;
          mrg_a = merges_r + MRG_W'(1);
        end
      end
      default: ;
    endcase

    case (ph_a)
      PH_HIGH: tail = len_a;
      PH_LOW:  tail = ((gap_a < gap_min_w) && (mrg_a < cfg.max_merges)) ?
                      sat_add(len_a, gap_a) : len_a;
      default: tail = '0;
    endcase
    sum_f = sat_add(sum_a, tail);

    if (final_req) begin
      cur_len_nxt = '0;
      cur_gap_nxt = '0;
      merges_nxt = '0;
      seen_nxt = '0;
      sum_nxt = '0;
    end else begin
      cur_len_nxt = len_a;
      cur_gap_nxt = gap_a;
      merges_nxt = mrg_a;
      seen_nxt = seen_a;
      sum_nxt = sum_a;
    end
  end

  always_comb begin
    rec_close.record_kind = KIND_PULSE;
    rec_close.pulse_length = out32(cur_len_r);
    rec_close.gap_length = out32(cur_gap_r);
    rec_close.pulse_total = out32(seen_a);
    rec_close.last = !final_req;
    rec_sum.record_kind = KIND_SUMMARY;
    rec_sum.pulse_length = out32(sum_f);
    rec_sum.gap_length = '0;
    rec_sum.pulse_total = out32(seen_a);
    rec_sum.last = 1'b1;
    res0 = close ? rec_close : rec_sum;
    res1 = rec_sum;
    n_push = go ? ({1'b0, close} + {1'b0, final_req}) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cur_len_r <= '0;
      cur_gap_r <= '0;
      merges_r <= '0;
      seen_r <= '0;
      sum_r <= '0;
    end else if (go) begin
      phase_r <= phase_nxt;
      cur_len_r <= cur_len_nxt;
      cur_gap_r <= cur_gap_nxt;
      merges_r <= merges_nxt;
      seen_r <= seen_nxt;
      sum_r <= sum_nxt;
    end
  end

endmodule

// File: design/pcgb_queue.sv
// Small record queue that accepts up to two records at once and releases one per cycle while pop is high.
module pcgb_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [1:0]     n_push,
  input  pcgb_pkg::res_t d0,
  input  pcgb_pkg::res_t d1,
  input  logic           pop,
  output logic           room2,
  output logic           valid,
  output pcgb_pkg::res_t dout
);
  import pcgb_pkg::*;

  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  res_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               do_pop;

  assign do_pop = pop && (cnt_r != '0);
  assign valid = (cnt_r != '0);
  assign dout = mem_r[rd_r];
  assign room2 = (cnt_r <= CNT_W'(Q_DEPTH - 2));

  always_comb begin
    wr_nxt = wr_r + Q_PTR_W'(n_push);
    rd_nxt = rd_r + Q_PTR_W'(do_pop);
    cnt_nxt = cnt_r + CNT_W'(n_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem_r[wr_r] <= d0;
    end
    if (n_push == 2'd2) begin
      mem_r[wr_r + Q_PTR_W'(1)] <= d1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_r <= wr_nxt;
      rd_r <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: design/pcgb_chk.sv
// Port-level checks on the result channel of the pulse counter.
module pcgb_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_record_kind,
  input logic [31:0] out_pulse_length,
  input logic [31:0] out_gap_length,
  input logic [31:0] out_pulse_total,
  input logic        out_last
);
  import pcgb_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pulse_length) &&
    $stable(out_record_kind) && $stable(out_pulse_total))
    else $error("Stalled result transaction changed.");

  a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_record_kind == KIND_SUMMARY) |-> out_last && (out_gap_length == '0))
    else $error("Summary record without last flag or with a gap length.");

  a_pulse_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_record_kind == KIND_PULSE) |->
    (out_pulse_length != '0) && (out_gap_length != '0) && (out_pulse_total != '0))
    else $error("Closed pulse record with a zero field.");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result offered right after reset.");

endmodule

bind pulse_counter_gap_bridging_top pcgb_chk u_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_record_kind  (out_ch.record_kind),
  .out_pulse_length (out_ch.pulse_length),
  .out_gap_length   (out_ch.gap_length),
  .out_pulse_total  (out_ch.pulse_total),
  .out_last         (out_ch.last)
);
